>>> src/dcc_pkg.sv
package dcc_pkg;

  localparam int MAX_DIGITS_DEF = 31;
  localparam int NUM_COMMANDS   = 16;
  localparam int PFX_SLOTS      = 16;
  localparam int PFX_MAXLEN     = 3;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_FREE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 2'd1;

  localparam logic [15:0] NODE_FREE_MASK_RST = 16'd53488;
  localparam logic [15:0] TIMEOUT_MS_RST     = 16'd3000;

  localparam logic [7:0] KEY_POLL = 8'd0;
  localparam logic [7:0] KEY_STAR = 8'd42;
  localparam logic [7:0] KEY_HASH = 8'd35;
  localparam logic [7:0] KEY_0    = 8'd48;
  localparam logic [7:0] KEY_9    = 8'd57;
  localparam logic [7:0] KEY_A    = 8'd65;
  localparam logic [7:0] KEY_D    = 8'd68;
  localparam logic [7:0] KEY_A_OFS = 8'd55;

  localparam logic [1:0] PFX_LEN [PFX_SLOTS] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd2,
    2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3};

  localparam logic [3:0] PFX_DIG [PFX_SLOTS][PFX_MAXLEN] = '{
    '{4'd1, 4'd0, 4'd0}, '{4'd2, 4'd0, 4'd0}, '{4'd3, 4'd0, 4'd0}, '{4'd4, 4'd0, 4'd0},
    '{4'd7, 4'd0, 4'd0}, '{4'd8, 4'd0, 4'd6}, '{4'd7, 4'd2, 4'd0}, '{4'd7, 4'd5, 4'd0},
    '{4'd8, 4'd1, 4'd1}, '{4'd8, 4'd1, 4'd2}, '{4'd8, 4'd1, 4'd3}, '{4'd7, 4'd3, 4'd0},
    '{4'd8, 4'd1, 4'd6}, '{4'd8, 4'd1, 4'd8}, '{4'd1, 4'd0, 4'd0}, '{4'd7, 4'd2, 4'd2}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic accept;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic do_emit;
    logic is_last;
  } stat_t;

endpackage

>>> src/dcc_ctrl.sv
module dcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  dcc_pkg::stat_t stat,
  output dcc_pkg::cmd_t  cmd
);

  dcc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.accept  = 1'b0;
    cmd.idx_inc = 1'b0;
    unique case (state_r)
      dcc_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.do_emit) begin
          state_nxt = dcc_pkg::ST_LOAD;
        end
      end
      dcc_pkg::ST_LOAD: begin
        state_nxt = dcc_pkg::ST_SHOW;
      end
      dcc_pkg::ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.is_last) begin
            state_nxt = dcc_pkg::ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = dcc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/dcc_dpath.sv
module dcc_dpath #(
  parameter int MAX_DIGITS = dcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    in_key_code,
  input  logic [31:0]                   in_time_ms,
  input  logic                          cfg_wr_en,
  input  logic [dcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata,
  input  dcc_pkg::cmd_t                 cmd,
  output dcc_pkg::stat_t                stat,
  output logic [3:0]                    out_digit_value,
  output logic                          out_last_digit
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  logic [15:0]   mask_r;
  logic [15:0]   tmo_r;
  logic          coll_r, coll_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   last_t_r, last_t_nxt;
  logic [3:0]    sh_r [dcc_pkg::PFX_MAXLEN];
  logic [AW-1:0] idx_r;
  logic [AW-1:0] rd_addr;
  logic [3:0]    rd_data_r;
  logic [3:0]    mem [MAX_DIGITS];

  logic          is_digit;
  logic [3:0]    val;
  logic [CW-1:0] new_cnt;
  logic [31:0]   elapsed;
  logic          exact, longer;
  logic          wr_en;
  logic          emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= dcc_pkg::NODE_FREE_MASK_RST;
      tmo_r  <= dcc_pkg::TIMEOUT_MS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dcc_pkg::CFG_NODE_FREE_MASK: mask_r <= cfg_wdata;
        dcc_pkg::CFG_TIMEOUT_MS:     tmo_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    is_digit = 1'b0;
    val      = 4'd0;
    if (in_key_code >= dcc_pkg::KEY_0 && in_key_code <= dcc_pkg::KEY_9) begin
      is_digit = 1'b1;
      val      = 4'(in_key_code - dcc_pkg::KEY_0);
    end else if (in_key_code >= dcc_pkg::KEY_A && in_key_code <= dcc_pkg::KEY_D) begin
      is_digit = 1'b1;
      val      = 4'(in_key_code - dcc_pkg::KEY_A_OFS);
    end
  end

  assign new_cnt = count_r + CW'(1);
  assign elapsed = in_time_ms - last_t_r;

  // prefix match on the first digits, including the one being appended
  always_comb begin
    logic       hit;
    logic       act;
    logic [3:0] cand;
    exact  = 1'b0;
    longer = 1'b0;
    for (int i = 0; i < dcc_pkg::PFX_SLOTS; i++) begin
      hit = (new_cnt <= CW'(dcc_pkg::PFX_LEN[i]));
      for (int k = 0; k < dcc_pkg::PFX_MAXLEN; k++) begin
        cand = (CW'(k) < count_r) ? sh_r[k] : val;
        if (CW'(k) < new_cnt && cand != dcc_pkg::PFX_DIG[i][k]) begin
          hit = 1'b0;
        end
      end
      act = (i < dcc_pkg::NUM_COMMANDS) && mask_r[i] && hit;
      if (act && new_cnt == CW'(dcc_pkg::PFX_LEN[i])) begin
        exact = 1'b1;
      end
      if (act && CW'(dcc_pkg::PFX_LEN[i]) > new_cnt) begin
        longer = 1'b1;
      end
    end
  end

  always_comb begin
    coll_nxt   = coll_r;
    count_nxt  = count_r;
    last_t_nxt = last_t_r;
    wr_en      = 1'b0;
    emit       = 1'b0;
    if (in_key_code == dcc_pkg::KEY_STAR) begin
      coll_nxt   = 1'b1;
      count_nxt  = '0;
      last_t_nxt = in_time_ms;
    end else if (coll_r) begin
      if (in_key_code == dcc_pkg::KEY_HASH) begin
        if (count_r == '0) begin
          coll_nxt = 1'b0;
        end else begin
          emit = 1'b1;
        end
      end else if (in_key_code == dcc_pkg::KEY_POLL) begin
        if (elapsed >= {16'd0, tmo_r}) begin
          if (count_r == '0) begin
            coll_nxt = 1'b0;
          end else begin
            emit = 1'b1;
          end
        end
      end else if (is_digit) begin
        if (count_r >= CW'(MAX_DIGITS)) begin
          coll_nxt = 1'b0;
        end else begin
          wr_en      = 1'b1;
          count_nxt  = new_cnt;
          last_t_nxt = in_time_ms;
          emit       = exact && !longer;
        end
      end else begin
        coll_nxt = 1'b0;
      end
    end
    if (emit) begin
      coll_nxt = 1'b0;
    end
  end

  assign stat.do_emit = emit;
  assign stat.is_last = ((CW'(idx_r) + CW'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r   <= 1'b0;
      count_r  <= '0;
      last_t_r <= '0;
      idx_r    <= '0;
    end else begin
      if (cmd.accept) begin
        coll_r   <= coll_nxt;
        count_r  <= count_nxt;
        last_t_r <= last_t_nxt;
        idx_r    <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      for (int k = 0; k < dcc_pkg::PFX_MAXLEN; k++) begin
        if (count_r == CW'(k)) begin
          sh_r[k] <= val;
        end
      end
    end
  end

  assign rd_addr = cmd.idx_inc ? (idx_r + AW'(1)) : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[count_r[AW-1:0]] <= val;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_digit_value = rd_data_r;
  assign out_last_digit  = stat.is_last;

endmodule

>>> src/dtmf_command_collector_top.sv
// Keypad item with no result: accepted while idle, and in_ready stays high.
// Item that completes a command: the state goes to LOAD, then to SHOW with the first digit beat; then one
// beat per cycle while out_ready is high, from the digit store read port.
// in_ready returns the cycle after the last beat.
// rst_n is synchronous, active low: idle, empty, config at reset values;
// the digit store is not cleared.
module dtmf_command_collector_top #(
  parameter int MAX_DIGITS = dcc_pkg::MAX_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_key_code,
  input  logic [31:0]                   in_time_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_digit_value,
  output logic                          out_last_digit,
  input  logic                          cfg_wr_en,
  input  logic [dcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_wdata
);

  dcc_pkg::cmd_t  cmd;
  dcc_pkg::stat_t stat;

  dcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dcc_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_key_code     (in_key_code),
    .in_time_ms      (in_time_ms),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_digit_value (out_digit_value),
    .out_last_digit  (out_last_digit)
  );

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while digits are being sent");

  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && stat.do_emit) |=> !in_ready ##1 out_valid)
    else $error("finished command did not start sending");

  a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_digit) |=> (in_ready && !out_valid))
    else $error("not idle after last digit beat");

  a_inc_only_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_inc |-> (out_valid && out_ready && !out_last_digit))
    else $error("read index moved without a beat");
`endif

endmodule
